@@ rtl/core/assert_macros.svh @@
// Assertion helpers for the core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rstn, prop, msg)
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg)
`endif
`endif

@@ rtl/core/ppi_pkg.sv @@
package ppi_pkg;
    localparam int CAPACITY_DEF = 256;
    localparam int IN_TDATA_W = 320;
    localparam int OUT_TDATA_W = 304;
    localparam int MAXP_W = 9;
    localparam int ENTRY_W = 352;

    localparam logic [1:0] ACT_SPAWN = 2'd0;
    localparam logic [1:0] ACT_STEP  = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;
    localparam logic [1:0] ACT_READ  = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_REFUSED = 2'd1;
    localparam logic [1:0] ST_NO_SLOT = 2'd2;

    typedef struct packed {
        logic [31:0] color;
        logic [31:0] size;
        logic [31:0] lifetime;
        logic [31:0] age;
        logic [31:0] acc_y;
        logic [31:0] acc_x;
        logic [31:0] vel_y;
        logic [31:0] vel_x;
        logic [31:0] pos_y;
        logic [31:0] pos_x;
        logic [31:0] id;
    } entry_t;
endpackage

@@ rtl/core/ppi_ram.sv @@
module ppi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ rtl/core/ppi_mul.sv @@
module ppi_mul (
    input  logic        aclk,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic [31:0] p_reg
);
    logic [31:0] full;
    assign full = a * b;

    always_ff @(posedge aclk) begin
        p_reg <= full;
    end
endmodule

@@ rtl/core/particle_pool_integrator.sv @@
// Particle pool with closed-form Euler integration. One request is taken at a
// time and one result comes back for each; the block is ready for the next
// request as soon as the current one is done, while its result waits in the
// output register. Spawn, clear, a refused read and a zero-tick step go from
// decode straight to the output state; a read first fetches its entry from
// memory. A step visits each live entry in turn: a registered memory read,
// a clamp of the ticks, a sequence through a single shared 32x32 multiplier
// whose products are added into the entry to compute the n-tick update in
// closed form, and, for a surviving particle, one write to the compacted
// position. A result that is not taken holds the block at the end of the
// following request.
// The pool sits in one single-port-write, registered-read RAM.
`include "assert_macros.svh"
module particle_pool_integrator #(
    parameter int CAPACITY = ppi_pkg::CAPACITY_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // action[1:0], start_x, start_y, start_vx, start_vy, accel_x, accel_y,
    // lifetime, particle_size, color_rgba, tick_count[15:0], slot[7:0], zero pad
    input  logic [ppi_pkg::IN_TDATA_W-1:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // status[1:0], particle_id, live_count[8:0], out_x, out_y, out_vx, out_vy,
    // out_age, out_lifetime, out_size, out_color, zero pad
    output logic [ppi_pkg::OUT_TDATA_W-1:0] m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [ppi_pkg::MAXP_W-1:0] cfg_data
);
    import ppi_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int RD = (CAPACITY > 1) ? CAPACITY : 2;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RD   = 4'd1;
    localparam logic [3:0] S_RDW  = 4'd2;
    localparam logic [3:0] S_EVAL = 4'd3;
    localparam logic [3:0] S_MUL  = 4'd4;
    localparam logic [3:0] S_WR   = 4'd5;
    localparam logic [3:0] S_OUT  = 4'd6;
    localparam logic [3:0] S_RDA  = 4'd7;

    logic [3:0]  state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] kept_reg, kept_next;
    logic [31:0] nid_reg, nid_next;
    logic [MAXP_W-1:0] maxp_reg;
    logic [IN_TDATA_W-1:0] req_reg, req_next;
    logic [OUT_TDATA_W-1:0] res_reg, res_next;
    logic [OUT_TDATA_W-1:0] work_reg, work_next;
    logic        out_v_reg, out_v_next;
    entry_t      ent_reg, ent_next;
    logic [31:0] n_reg, n_next, tri_reg, tri_next;
    logic        dies_reg, dies_next;
    logic [3:0]  ph_reg, ph_next;

    logic [1:0]  act;
    logic [31:0] in_f [9];
    logic [15:0] ticks;
    logic [7:0]  slot;
    assign act   = req_reg[1:0];
    assign ticks = req_reg[305:290];
    assign slot  = req_reg[313:306];
    always_comb begin
        for (int k = 0; k < 9; k++) begin
            in_f[k] = req_reg[2 + 32*k +: 32];
        end
    end

    logic          we;
    logic [AW-1:0] waddr, raddr;
    entry_t        wdata, rdata;
    ppi_ram #(.WIDTH(ENTRY_W), .DEPTH(RD)) u_ram (
        .aclk(aclk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    logic [31:0] ma, mb, mp;
    ppi_mul u_mul (.aclk(aclk), .a(ma), .b(mb), .p_reg(mp));

    logic [CW-1:0] limit;
    assign limit = (32'(maxp_reg) > 32'(CAPACITY)) ? CW'(CAPACITY) : CW'(maxp_reg);

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_v_reg;
    assign m_tdata   = res_reg;

    logic [31:0] remain;
    assign remain = ent_reg.lifetime - ent_reg.age;

    always_comb begin
        ma = n_reg;
        mb = 32'd0;
        case (ph_reg)
            4'd0: begin ma = n_reg; mb = n_reg + 32'd1; end
            4'd1: begin ma = n_reg; mb = ent_reg.vel_x; end
            4'd2: begin ma = tri_reg; mb = ent_reg.acc_x; end
            4'd3: begin ma = n_reg; mb = ent_reg.vel_y; end
            4'd4: begin ma = tri_reg; mb = ent_reg.acc_y; end
            4'd5: begin ma = n_reg; mb = ent_reg.acc_x; end
            4'd6: begin ma = n_reg; mb = ent_reg.acc_y; end
            default: begin ma = 32'd0; mb = 32'd0; end
        endcase
    end

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        kept_next  = kept_reg;
        nid_next   = nid_reg;
        req_next   = req_reg;
        res_next   = res_reg;
        work_next  = work_reg;
        out_v_next = out_v_reg;
        ent_next   = ent_reg;
        n_next     = n_reg;
        tri_next   = tri_reg;
        dies_next  = dies_reg;
        ph_next    = ph_reg;
        we         = 1'b0;
        waddr      = AW'(kept_reg);
        wdata      = ent_reg;
        raddr      = AW'(idx_reg);

        if (out_v_reg && m_tready) begin
            out_v_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid && s_tready) begin
                    req_next   = s_tdata;
                    state_next = S_RD;
                end
            end
            S_RD: begin
                work_next = '0;
                case (act)
                    ACT_SPAWN: begin
                        if (count_reg >= limit || nid_reg == 32'd0) begin
                            work_next[1:0] = ST_REFUSED;
                        end else begin
                            we    = 1'b1;
                            waddr = AW'(count_reg);
                            wdata.id = nid_reg;
                            wdata.pos_x = in_f[0];
                            wdata.pos_y = in_f[1];
                            wdata.vel_x = in_f[2];
                            wdata.vel_y = in_f[3];
                            wdata.acc_x = in_f[4];
                            wdata.acc_y = in_f[5];
                            wdata.lifetime = in_f[6];
                            wdata.age = 32'd0;
                            wdata.size = in_f[7];
                            wdata.color = in_f[8];
                            work_next[33:2] = nid_reg;
                            nid_next   = nid_reg + 32'd1;
                            count_next = count_reg + CW'(1);
                        end
                        state_next = S_OUT;
                    end
                    ACT_STEP: begin
                        idx_next  = '0;
                        kept_next = '0;
                        state_next = (ticks == 16'd0) ? S_OUT : S_RDA;
                    end
                    ACT_CLEAR: begin
                        count_next = '0;
                        nid_next   = 32'd1;
                        state_next = S_OUT;
                    end
                    default: begin
                        if (CW'(slot) >= count_reg || 32'(slot) >= 32'(CAPACITY)) begin
                            work_next[1:0] = ST_NO_SLOT;
                            state_next = S_OUT;
                        end else begin
                            idx_next   = CW'(slot);
                            state_next = S_RDA;
                        end
                    end
                endcase
            end
            S_RDA: begin
                if (act == ACT_STEP && idx_reg >= count_reg) begin
                    count_next = kept_reg;
                    state_next = S_OUT;
                end else begin
                    state_next = S_RDW;
                end
            end
            S_RDW: begin
                ent_next = rdata;
                if (act == ACT_READ) begin
                    work_next[33:2]    = rdata.id;
                    work_next[74:43]   = rdata.pos_x;
                    work_next[106:75]  = rdata.pos_y;
                    work_next[138:107] = rdata.vel_x;
                    work_next[170:139] = rdata.vel_y;
                    work_next[202:171] = rdata.age;
                    work_next[234:203] = rdata.lifetime;
                    work_next[266:235] = rdata.size;
                    work_next[298:267] = rdata.color;
                    state_next = S_OUT;
                end else begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL: begin
                if (ent_reg.age < ent_reg.lifetime) begin
                    if (32'(ticks) < remain) begin
                        n_next = 32'(ticks);
                        dies_next = 1'b0;
                    end else begin
                        n_next = remain;
                        dies_next = 1'b1;
                    end
                    ent_next.age = ent_reg.age + ((32'(ticks) < remain) ? 32'(ticks) : remain);
                end else begin
                    n_next = 32'd1;
                    dies_next = 1'b1;
                end
                ph_next = 4'd0;
                state_next = S_MUL;
            end
            S_MUL: begin
                ph_next = ph_reg + 4'd1;
                case (ph_reg)
                    4'd1: tri_next = {1'b0, mp[31:1]};
                    4'd2: ent_next.pos_x = ent_reg.pos_x + mp;
                    4'd3: ent_next.pos_x = ent_reg.pos_x + mp;
                    4'd4: ent_next.pos_y = ent_reg.pos_y + mp;
                    4'd5: ent_next.pos_y = ent_reg.pos_y + mp;
                    4'd6: ent_next.vel_x = ent_reg.vel_x + mp;
                    4'd7: begin
                        ent_next.vel_y = ent_reg.vel_y + mp;
                        state_next = S_WR;
                    end
                    default: ;
                endcase
            end
            S_WR: begin
                if (!dies_reg) begin
                    we = 1'b1;
                    kept_next = kept_reg + CW'(1);
                end
                idx_next   = idx_reg + CW'(1);
                state_next = S_RDA;
            end
            S_OUT: begin
                if (!out_v_reg || m_tready) begin
                    res_next = work_reg;
                    res_next[42:34] = 9'(count_reg);
                    out_v_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            nid_reg   <= 32'd1;
            maxp_reg  <= MAXP_W'(256);
            out_v_reg <= 1'b0;
            idx_reg   <= '0;
            kept_reg  <= '0;
            ph_reg    <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            nid_reg   <= nid_next;
            out_v_reg <= out_v_next;
            idx_reg   <= idx_next;
            kept_reg  <= kept_next;
            ph_reg    <= ph_next;
            if (cfg_valid && cfg_ready) begin
                maxp_reg <= cfg_data;
            end
        end
        req_reg  <= req_next;
        res_reg  <= res_next;
        work_reg <= work_next;
        ent_reg  <= ent_next;
        n_reg    <= n_next;
        tri_reg  <= tri_next;
        dies_reg <= dies_next;
    end

    `ASSERT_CLK(a_count_cap, aclk, aresetn, (count_reg <= CW'(CAPACITY)), "pool count beyond capacity")
    `ASSERT_CLK(a_kept_le_idx, aclk, aresetn, (state_reg != S_WR || kept_reg <= idx_reg), "compaction ahead of walk")
    `ASSERT_NEXT(a_out_hold, aclk, aresetn, (m_tvalid && !m_tready), (m_tvalid && $stable(m_tdata)), "result dropped")
endmodule

@@ dv/tb_particle_pool_integrator.sv @@
`timescale 1ns / 100ps

module tb_particle_pool_integrator;
    import ppi_pkg::*;

    localparam int POOL_DEPTH   = 256;
    localparam int CYCLE_LIMIT  = 6_000_000;
    localparam int DRAIN_CYCLES = 4000;

    typedef struct packed {
        logic [7:0]  slot;
        logic [15:0] ticks;
        logic [31:0] color;
        logic [31:0] psize;
        logic [31:0] life;
        logic [31:0] ay;
        logic [31:0] ax;
        logic [31:0] vy;
        logic [31:0] vx;
        logic [31:0] y;
        logic [31:0] x;
        logic [1:0]  action;
    } request_t;

    typedef struct packed {
        logic [31:0] color;
        logic [31:0] psize;
        logic [31:0] life;
        logic [31:0] age;
        logic [31:0] vy;
        logic [31:0] vx;
        logic [31:0] y;
        logic [31:0] x;
        logic [8:0]  live;
        logic [31:0] id;
        logic [1:0]  status;
    } answer_t;

    typedef struct {
        bit           is_limit;
        logic [8:0]   limit;
        request_t     req;
    } pending_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_TDATA_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [MAXP_W-1:0] cfg_data = '0;

    particle_pool_integrator dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    // pool mirror
    logic [31:0] pool_id   [POOL_DEPTH];
    logic [31:0] pool_x    [POOL_DEPTH];
    logic [31:0] pool_y    [POOL_DEPTH];
    logic [31:0] pool_vx   [POOL_DEPTH];
    logic [31:0] pool_vy   [POOL_DEPTH];
    logic [31:0] pool_ax   [POOL_DEPTH];
    logic [31:0] pool_ay   [POOL_DEPTH];
    logic [31:0] pool_age  [POOL_DEPTH];
    logic [31:0] pool_life [POOL_DEPTH];
    logic [31:0] pool_size [POOL_DEPTH];
    logic [31:0] pool_color[POOL_DEPTH];
    int unsigned live_total = 0;
    logic [31:0] id_counter = 32'd1;
    logic [8:0]  pool_limit = 9'd256;

    pending_t pending_q[$];
    answer_t  answer_q[$];
    int       errors = 0;
    int       cycles = 0;

    function automatic answer_t apply_request(request_t r);
        answer_t a;
        int unsigned cap, kept, n, remain;
        logic [31:0] n32, tri_sum;
        logic [63:0] prod;
        bit dies;
        a = '0;
        cap = (pool_limit < POOL_DEPTH) ? pool_limit : POOL_DEPTH;
        case (r.action)
            ACT_SPAWN: begin
                if (live_total >= cap || id_counter == 32'd0) begin
                    a.status = ST_REFUSED;
                end else begin
                    pool_id[live_total]    = id_counter;
                    pool_x[live_total]     = r.x;
                    pool_y[live_total]     = r.y;
                    pool_vx[live_total]    = r.vx;
                    pool_vy[live_total]    = r.vy;
                    pool_ax[live_total]    = r.ax;
                    pool_ay[live_total]    = r.ay;
                    pool_life[live_total]  = r.life;
                    pool_age[live_total]   = '0;
                    pool_size[live_total]  = r.psize;
                    pool_color[live_total] = r.color;
                    a.id = id_counter;
                    id_counter = id_counter + 32'd1;
                    live_total++;
                end
            end
            ACT_STEP: begin
                if (r.ticks != 0) begin
                    kept = 0;
                    for (int i = 0; i < live_total; i++) begin
                        if (pool_age[i] < pool_life[i]) begin
                            remain = pool_life[i] - pool_age[i];
                            n = (r.ticks < remain) ? r.ticks : remain;
                            pool_age[i] = pool_age[i] + n;
                            dies = (n == remain);
                        end else begin
                            n = 1;
                            dies = 1'b1;
                        end
                        n32 = n;
                        prod = 64'(n) * 64'(n + 1);
                        tri_sum = prod[32:1];
                        pool_x[i]  = pool_x[i] + n32 * pool_vx[i] + tri_sum * pool_ax[i];
                        pool_y[i]  = pool_y[i] + n32 * pool_vy[i] + tri_sum * pool_ay[i];
                        pool_vx[i] = pool_vx[i] + n32 * pool_ax[i];
                        pool_vy[i] = pool_vy[i] + n32 * pool_ay[i];
                        if (!dies) begin
                            pool_id[kept]    = pool_id[i];
                            pool_x[kept]     = pool_x[i];
                            pool_y[kept]     = pool_y[i];
                            pool_vx[kept]    = pool_vx[i];
                            pool_vy[kept]    = pool_vy[i];
                            pool_ax[kept]    = pool_ax[i];
                            pool_ay[kept]    = pool_ay[i];
                            pool_age[kept]   = pool_age[i];
                            pool_life[kept]  = pool_life[i];
                            pool_size[kept]  = pool_size[i];
                            pool_color[kept] = pool_color[i];
                            kept++;
                        end
                    end
                    live_total = kept;
                end
            end
            ACT_CLEAR: begin
                live_total = 0;
                id_counter = 32'd1;
            end
            default: begin
                if (r.slot >= live_total) begin
                    a.status = ST_NO_SLOT;
                end else begin
                    a.id    = pool_id[r.slot];
                    a.x     = pool_x[r.slot];
                    a.y     = pool_y[r.slot];
                    a.vx    = pool_vx[r.slot];
                    a.vy    = pool_vy[r.slot];
                    a.age   = pool_age[r.slot];
                    a.life  = pool_life[r.slot];
                    a.psize = pool_size[r.slot];
                    a.color = pool_color[r.slot];
                end
            end
        endcase
        a.live = live_total[8:0];
        return a;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'hFFFF_FFFF;
            3: return $urandom_range(0, 40) - 20;
            default: return $urandom;
        endcase
    endfunction

    function automatic request_t random_request(int unsigned spawn_weight);
        request_t r;
        int unsigned pick;
        r = '0;
        pick = $urandom_range(0, 99);
        if (pick < spawn_weight) r.action = ACT_SPAWN;
        else if (pick < spawn_weight + (100 - spawn_weight) * 4 / 10) r.action = ACT_READ;
        else if (pick < 96) r.action = ACT_STEP;
        else r.action = ACT_CLEAR;
        r.x = pick_word();
        r.y = pick_word();
        r.vx = pick_word();
        r.vy = pick_word();
        r.ax = pick_word();
        r.ay = pick_word();
        case ($urandom_range(0, 9))
            0: r.life = 32'd0;
            1: r.life = 32'hFFFF_FFFF;
            2: r.life = $urandom;
            default: r.life = $urandom_range(0, 40);
        endcase
        r.psize = $urandom;
        r.color = $urandom;
        case ($urandom_range(0, 9))
            0: r.ticks = 16'd0;
            1: r.ticks = 16'hFFFF;
            2: r.ticks = 16'($urandom);
            default: r.ticks = 16'($urandom_range(1, 12));
        endcase
        r.slot = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 20));
        return r;
    endfunction

    task automatic queue_request(request_t r);
        pending_t p;
        p.is_limit = 1'b0;
        p.limit = '0;
        p.req = r;
        pending_q.insert(pending_q.size(), p);
    endtask

    task automatic queue_limit(logic [8:0] v);
        pending_t p;
        p.is_limit = 1'b1;
        p.limit = v;
        p.req = '0;
        pending_q.insert(pending_q.size(), p);
    endtask

    task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            errors++;
            if (errors <= 10)
                $display("mismatch %s: expected %h got %h", name, exp_v, act_v);
        end
    endtask

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // driver
    int unsigned req_gap = 0;
    request_t    cur_req = '0;
    always @(posedge aclk) begin
        logic nxt_valid, nxt_cfg;
        pending_t p;
        answer_t ans;
        if (!aresetn) begin
            s_tvalid  <= 1'b0;
            cfg_valid <= 1'b0;
        end else begin
            nxt_valid = s_tvalid;
            nxt_cfg = cfg_valid;
            if (s_tvalid && s_tready) begin
                ans = apply_request(cur_req);
                answer_q.insert(answer_q.size(), ans);
                nxt_valid = 1'b0;
            end
            if (cfg_valid && cfg_ready) begin
                pool_limit = cfg_data;
                nxt_cfg = 1'b0;
            end
            if (!nxt_valid && !nxt_cfg) begin
                if (req_gap > 0) begin
                    req_gap--;
                end else if (pending_q.size() > 0) begin
                    p = pending_q[0];
                    if (!p.is_limit) begin
                        void'(pending_q.pop_front());
                        cur_req = p.req;
                        s_tdata <= IN_TDATA_W'(p.req);
                        nxt_valid = 1'b1;
                        req_gap = pick_gap();
                    end else if (answer_q.size() == 0 && !s_tvalid) begin
                        void'(pending_q.pop_front());
                        cfg_data <= p.limit;
                        nxt_cfg = 1'b1;
                    end
                end
            end
            s_tvalid  <= nxt_valid;
            cfg_valid <= nxt_cfg;
        end
    end

    // monitor
    int unsigned stall = 0;
    always @(posedge aclk) begin
        answer_t got, want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got = answer_t'(m_tdata[$bits(answer_t)-1:0]);
                if (answer_q.size() == 0) begin
                    errors++;
                    if (errors <= 10) $display("unexpected result %h", got);
                end else begin
                    want = answer_q.pop_front();
                    check_field("status", 32'(want.status), 32'(got.status));
                    check_field("particle_id", want.id, got.id);
                    check_field("live_count", 32'(want.live), 32'(got.live));
                    check_field("out_x", want.x, got.x);
                    check_field("out_y", want.y, got.y);
                    check_field("out_vx", want.vx, got.vx);
                    check_field("out_vy", want.vy, got.vy);
                    check_field("out_age", want.age, got.age);
                    check_field("out_lifetime", want.life, got.life);
                    check_field("out_size", want.psize, got.psize);
                    check_field("out_color", want.color, got.color);
                end
            end
            if (stall > 0) begin
                stall--;
                m_tready <= 1'b0;
            end else begin
                stall = pick_gap();
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        request_t r;
        logic [8:0] limits[7] = '{9'd8, 9'd300, 9'd3, 9'd511, 9'd16, 9'd0, 9'd256};
        int unsigned spawn_w;

        // directed
        r = '0;
        r.action = ACT_SPAWN;
        r.x = 32'h7FFF_FFFF; r.y = 32'h8000_0000;
        r.vx = 32'h7FFF_FFFF; r.vy = 32'h8000_0000;
        r.ax = 32'hFFFF_FFFF; r.ay = 32'h0000_0001;
        r.life = 32'd0; r.psize = 32'hFFFF_FFFF; r.color = 32'hA5A5_5A5A;
        r.ticks = 16'hFFFF; r.slot = 8'hFF;
        queue_request(r);
        r.x = 32'h8000_0000; r.y = 32'h7FFF_FFFF; r.life = 32'hFFFF_FFFF;
        r.ax = 32'h8000_0000; r.ay = 32'h7FFF_FFFF; r.psize = '0; r.color = 32'hFFFF_FFFF;
        queue_request(r);
        r.life = 32'd3; r.x = 32'd5; r.vx = 32'hFFFF_FFFE; r.ax = 32'd1;
        queue_request(r);
        r.action = ACT_READ; r.slot = 8'd0; queue_request(r);
        r.slot = 8'd2; queue_request(r);
        r.slot = 8'd3; queue_request(r);
        r.slot = 8'hFF; queue_request(r);
        r.action = ACT_STEP; r.ticks = 16'd0; queue_request(r);
        r.action = ACT_READ; r.slot = 8'd0; queue_request(r);
        r.action = ACT_STEP; r.ticks = 16'd1; queue_request(r);
        r.action = ACT_READ; r.slot = 8'd0; queue_request(r);
        r.slot = 8'd1; queue_request(r);
        r.action = ACT_STEP; r.ticks = 16'hFFFF; queue_request(r);
        r.action = ACT_READ; r.slot = 8'd0; queue_request(r);
        r.action = ACT_CLEAR; queue_request(r);
        r.action = ACT_READ; r.slot = 8'd0; queue_request(r);
        r.action = ACT_SPAWN; queue_request(r);
        queue_limit(9'd1);
        queue_request(r);
        queue_request(r);
        queue_limit(9'd0);
        r.action = ACT_CLEAR; queue_request(r);
        r.action = ACT_SPAWN; queue_request(r);

        // random phases under several pool limits
        foreach (limits[k]) begin
            queue_limit(limits[k]);
            spawn_w = (limits[k] > 16) ? 35 : 45;
            for (int i = 0; i < 125; i++) queue_request(random_request(spawn_w));
        end
        // fill the whole pool, then run it
        r = '0;
        r.action = ACT_CLEAR;
        queue_request(r);
        for (int i = 0; i < 258; i++) begin
            r = random_request(100);
            r.action = ACT_SPAWN;
            r.life = $urandom_range(0, 6);
            queue_request(r);
        end
        for (int i = 0; i < 12; i++) begin
            r = random_request(0);
            if (r.action == ACT_CLEAR) r.action = ACT_READ;
            if (r.action == ACT_STEP) r.ticks = 16'($urandom_range(0, 2));
            queue_request(r);
        end

        wait (aresetn);
        while (pending_q.size() > 0 || s_tvalid || cfg_valid || answer_q.size() > 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (errors == 0 && answer_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
